/* rtl/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared widths, character codes, controller states, command/status bundles
// and the digit-to-ASCII mapping for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int WORD_W              = 32;
    localparam int STEP_W              = $clog2(WORD_W);
    localparam int RADIX_W             = 6;
    localparam int CHAR_W              = 7;
    localparam int DIGIT_STORE_DEPTH_D = 32;

    localparam logic [RADIX_W-1:0] DEFAULT_RADIX = 6'd10;
    localparam logic [RADIX_W-1:0] MAX_RADIX     = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 7'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIV,
        ST_STORE,
        ST_READ,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic rd;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic neg;
        logic step_done;
        logic quo_zero;
        logic last_digit;
        logic out_free;
    } status_t;

    // Map a digit value (below the radix) to its ASCII code
    function automatic logic [CHAR_W-1:0] digit_char(
        input logic [RADIX_W-1:0] d,
        input logic               upper
    );
        logic [CHAR_W-1:0] dw;
        logic [CHAR_W-1:0] base;
        dw   = {1'b0, d};
        base = upper ? CHAR_UP_A : CHAR_LOW_A;
        if (d < DEFAULT_RADIX)
        begin
            digit_char = CHAR_ZERO + dw;
        end
        else
        begin
            digit_char = base + (dw - {1'b0, DEFAULT_RADIX});
        end
    endfunction

endpackage

/* rtl/itoa_ctrl.sv */
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer for one conversion: sign, repeated division, digit readout.
// ----------------------------------------------------------------------------
module itoa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  itoa_pkg::status_t sts,
    output itoa_pkg::cmd_t    cmd
);
    import itoa_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (!sts.neg || sts.out_free)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.step_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                state_next = sts.quo_zero ? ST_READ : ST_DIV;
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.last_digit ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = sts.neg && sts.out_free;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/itoa_datapath.sv */
// ----------------------------------------------------------------------------
// itoa_datapath
// Restoring divider by the radix, digit store and output register.
// ----------------------------------------------------------------------------
module itoa_datapath #(
    parameter int DIGIT_STORE_DEPTH = itoa_pkg::DIGIT_STORE_DEPTH_D
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [itoa_pkg::WORD_W-1:0]   value,
    input  logic                          signed_mode,
    input  logic [itoa_pkg::RADIX_W-1:0]  radix,
    input  logic                          upper_case,
    input  itoa_pkg::cmd_t                cmd,
    output itoa_pkg::status_t             sts,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [itoa_pkg::CHAR_W-1:0]   character,
    output logic                          last
);
    import itoa_pkg::*;

    localparam int ADDR_W = $clog2(DIGIT_STORE_DEPTH);

    logic [WORD_W-1:0]  num_reg;
    logic [RADIX_W-1:0] acc_reg;
    logic [RADIX_W-1:0] radix_reg;
    logic               upper_reg;
    logic               neg_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [ADDR_W-1:0]  ptr_reg;
    logic [CHAR_W-1:0]  rd_data_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [CHAR_W-1:0]  digit_mem [DIGIT_STORE_DEPTH];

    logic [RADIX_W-1:0] radix_norm;
    logic               neg_in;
    logic [RADIX_W:0]   shifted;
    logic [RADIX_W:0]   diff;
    logic               ge;
    logic [RADIX_W-1:0] acc_next;
    logic [ADDR_W-1:0]  rd_addr;
    logic               out_free;

    // Normalize radix and detect sign at intake
    always_comb
    begin
        radix_norm = radix;
        if (radix <= 6'd1)
        begin
            radix_norm = DEFAULT_RADIX;
        end
        else if (radix > MAX_RADIX)
        begin
            radix_norm = MAX_RADIX;
        end
    end

    assign neg_in = signed_mode && value[WORD_W-1];

    // One restoring division step
    assign shifted  = {acc_reg, num_reg[WORD_W-1]};
    assign ge       = shifted >= {1'b0, radix_reg};
    assign diff     = shifted - {1'b0, radix_reg};
    assign acc_next = ge ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];

    // Hold operand, remainder and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            ptr_reg  <= '0;
        end
        else if (cmd.load)
        begin
            step_reg <= '0;
            ptr_reg  <= '0;
        end
        else if (cmd.step)
        begin
            step_reg <= step_reg + STEP_W'(1);
        end
        else if (cmd.store)
        begin
            step_reg <= '0;
            ptr_reg  <= ptr_reg + ADDR_W'(1);
        end
        else if (cmd.emit_digit)
        begin
            ptr_reg <= ptr_reg - ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg   <= neg_in ? (~value + WORD_W'(1)) : value;
            acc_reg   <= '0;
            radix_reg <= radix_norm;
            upper_reg <= upper_case;
            neg_reg   <= neg_in;
        end
        else if (cmd.step)
        begin
            num_reg <= {num_reg[WORD_W-2:0], ge};
            acc_reg <= acc_next;
        end
        else if (cmd.store)
        begin
            acc_reg <= '0;
        end
    end

    // Digit store: write remainders, read back most significant first
    assign rd_addr = ptr_reg - ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            digit_mem[ptr_reg] <= digit_char(acc_reg, upper_reg);
        end
        if (cmd.rd)
        begin
            rd_data_reg <= digit_mem[rd_addr];
        end
    end

    // Output register
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= rd_data_reg;
            last_reg <= (ptr_reg == ADDR_W'(1));
        end
    end

    // Report status
    always_comb
    begin
        sts.neg        = neg_reg;
        sts.step_done  = (step_reg == STEP_W'(WORD_W - 1));
        sts.quo_zero   = (num_reg == '0);
        sts.last_digit = (ptr_reg == ADDR_W'(1));
        sts.out_free   = out_free;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

/* rtl/integer_to_ascii_radix.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Sequence: an accepted word is loaded, then each digit takes 32 divide steps
// and a store, least significant first; a minus sign goes out before division.
// Digits are then read back and emitted one at a time, most significant first,
// each emit waiting while the output stalls. Speed is set by the bit-serial
// restoring divider. Input is taken only when idle, after the last digit.
// Reset: asynchronous, active low; clears controller state and output valid.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
    parameter int DIGIT_STORE_DEPTH = itoa_pkg::DIGIT_STORE_DEPTH_D
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [itoa_pkg::WORD_W-1:0]   value,
    input  logic                          signed_mode,
    input  logic [itoa_pkg::RADIX_W-1:0]  radix,
    input  logic                          upper_case,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [itoa_pkg::CHAR_W-1:0]   character,
    output logic                          last
);
    import itoa_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // Sequencer
    itoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Divider, digit store and output register
    itoa_datapath #(
        .DIGIT_STORE_DEPTH (DIGIT_STORE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .signed_mode (signed_mode),
        .radix       (radix),
        .upper_case  (upper_case),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .character   (character),
        .last        (last)
    );

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench for integer_to_ascii_radix
// Drives words through the valid/stall input channel and checks every output
// character and its last mark against the table text or a behavioral digit
// speller. A directed table covers zero, sign handling, the radix limits and
// letter case. Random words follow, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import itoa_pkg::*;

    localparam int PLAN_ROWS    = 24;
    localparam int RANDOM_WORDS = 306;
    localparam int STUCK_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 1200;

    // One output character as it should appear on the result channel
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } glyph_t;

    // One directed row; an empty text means the speller supplies the result
    typedef struct {
        logic [WORD_W-1:0]  number;
        logic               sgn;
        logic [RADIX_W-1:0] base;
        logic               upper;
        string              text;
    } word_row_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [WORD_W-1:0]    value       = '0;
    logic                 signed_mode = 1'b0;
    logic [RADIX_W-1:0]   radix       = '0;
    logic                 upper_case  = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [CHAR_W-1:0]    character;
    logic                 last;

    glyph_t pending_chars[$];
    int     fail_count   = 0;
    int     stuck_cycles = 0;
    logic   gaps_on      = 1'b1;

    word_row_t plan [PLAN_ROWS] = '{
        '{32'h0000_0000, 1'b0, 6'd10, 1'b0, "0"},
        '{32'h0000_0000, 1'b1, 6'd16, 1'b1, "0"},
        '{32'hFFFF_FFFF, 1'b1, 6'd10, 1'b0, "-1"},
        '{32'h8000_0000, 1'b1, 6'd10, 1'b0, "-2147483648"},
        '{32'hFFFF_FFFF, 1'b0, 6'd10, 1'b0, "4294967295"},
        '{32'hFFFF_FFFF, 1'b0, 6'd16, 1'b1, "FFFFFFFF"},
        '{32'hFFFF_FFFF, 1'b0, 6'd16, 1'b0, "ffffffff"},
        '{32'hFFFF_FFFF, 1'b0, 6'd2,  1'b0, "11111111111111111111111111111111"},
        '{32'h8000_0000, 1'b1, 6'd2,  1'b0, "-10000000000000000000000000000000"},
        '{32'h0000_00FF, 1'b0, 6'd0,  1'b0, "255"},
        '{32'h0000_00FF, 1'b0, 6'd1,  1'b1, "255"},
        '{32'h0000_0023, 1'b0, 6'd36, 1'b0, "z"},
        '{32'h0000_0023, 1'b0, 6'd36, 1'b1, "Z"},
        '{32'h0000_0024, 1'b0, 6'd36, 1'b0, "10"},
        '{32'h7FFF_FFFF, 1'b1, 6'd10, 1'b0, "2147483647"},
        '{32'h0000_0001, 1'b1, 6'd2,  1'b0, "1"},
        '{32'h0000_000A, 1'b0, 6'd11, 1'b1, "A"},
        '{32'h0000_000A, 1'b0, 6'd11, 1'b0, "a"},
        '{32'h0000_0009, 1'b1, 6'd10, 1'b0, "9"},
        '{32'hFFFF_FFFF, 1'b0, 6'd36, 1'b0, ""},
        '{32'h8000_0000, 1'b1, 6'd36, 1'b1, ""},
        '{32'hAAAA_AAAA, 1'b0, 6'd32, 1'b1, ""},
        '{32'h5555_5555, 1'b1, 6'd33, 1'b0, ""},
        '{32'hFFFF_FFFE, 1'b1, 6'd3,  1'b0, ""}
    };

    integer_to_ascii_radix dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .signed_mode (signed_mode),
        .radix       (radix),
        .upper_case  (upper_case),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .character   (character),
        .last        (last)
    );

    // Free-running 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Spell a word in the selected base and queue its characters
    function automatic void spell_number(
        input logic [WORD_W-1:0]  number,
        input logic               sgn,
        input logic [RADIX_W-1:0] base_in,
        input logic               upper
    );
        logic [WORD_W-1:0] mag;
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] rem;
        logic [7:0]        code;
        glyph_t            digits[$];
        glyph_t            g;
        base = WORD_W'(base_in);
        if (base <= 1)
        begin
            base = 10;
        end
        if (base > 36)
        begin
            base = 36;
        end
        mag = number;
        // emit the sign and take the magnitude
        if (sgn && number[WORD_W-1])
        begin
            pending_chars.push_back('{code: CHAR_MINUS, fin: 1'b0});
            mag = ~number + 1'b1;
        end
        if (mag == 0)
        begin
            pending_chars.push_back('{code: CHAR_ZERO, fin: 1'b1});
            return;
        end
        // peel digits least significant first
        while (mag != 0)
        begin
            rem = mag % base;
            mag = mag / base;
            if (rem < 10)
            begin
                code = 8'("0" + rem);
            end
            else
            begin
                code = 8'((upper ? "A" : "a") + rem - 10);
            end
            digits.push_front('{code: code[CHAR_W-1:0], fin: 1'b0});
        end
        digits[digits.size() - 1].fin = 1'b1;
        foreach (digits[i])
        begin
            g = digits[i];
            pending_chars.push_back(g);
        end
    endfunction

    // Present one word, hold it until the beat is taken, then queue its text
    task automatic send_word(
        input logic [WORD_W-1:0]  number,
        input logic               sgn,
        input logic [RADIX_W-1:0] base,
        input logic               upper,
        input string              text
    );
        int  n;
        byte ch;
        while (gaps_on && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        value       <= number;
        signed_mode <= sgn;
        radix       <= base;
        upper_case  <= upper;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (text.len() == 0)
        begin
            spell_number(number, sgn, base, upper);
        end
        else
        begin
            for (n = 0; n < text.len(); n++)
            begin
                ch = text[n];
                pending_chars.push_back('{code: ch[CHAR_W-1:0],
                                          fin: (n == text.len() - 1)});
            end
        end
    endtask

    // Hold off the sender until every queued character has come out
    task automatic drain_pending();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Stall the result channel at random
    always @(posedge clk)
    begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < 7);
    end

    // Check each result beat and watch for a hung channel
    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected character %h last %b", character, last);
                    fail_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (character !== want.code)
                    begin
                        $error("character: expected %h, got %h", want.code, character);
                        fail_count++;
                    end
                    if (last !== want.fin)
                    begin
                        $error("last: expected %b, got %b", want.fin, last);
                        fail_count++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                stuck_cycles <= 0;
            end
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("integer_to_ascii_radix: mismatch");
                $finish;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // Reset, directed table, random words, drain
    initial
    begin
        logic [WORD_W-1:0]  number;
        logic [RADIX_W-1:0] base;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (plan[i])
        begin
            send_word(plan[i].number, plan[i].sgn, plan[i].base, plan[i].upper,
                      plan[i].text);
        end
        drain_pending();
        @(posedge clk);

        // random words, with a quiet stretch and one more full drain
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            gaps_on = !(k >= 120 && k < 200);
            case ($urandom_range(0, 5))
                0: number = $urandom_range(0, 40);
                1: number = 32'hFFFF_FFFF - $urandom_range(0, 40);
                2: number = 32'h8000_0000 + $urandom_range(0, 40);
                3: number = $urandom | 32'h8000_0000;
                default: number = $urandom;
            endcase
            base = RADIX_W'($urandom_range(0, 36));
            send_word(number, 1'($urandom), base, 1'($urandom), "");
            if (k == 60)
            begin
                drain_pending();
                @(posedge clk);
            end
        end
        gaps_on = 1'b1;

        // wait out the tail, then report
        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_chars.size() == 0)
        begin
            $display("integer_to_ascii_radix: match");
        end
        else
        begin
            $display("integer_to_ascii_radix: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/itoa_pkg.sv
rtl/itoa_ctrl.sv
rtl/itoa_datapath.sv
rtl/integer_to_ascii_radix.sv
sim/testbench.sv
